>>> src/d2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix to quaternion package
// Shared payload types, widths and branch codes for the conversion block.
// ----------------------------------------------------------------------------
package d2q_pkg;

  localparam int unsigned ELEM_W = 32;
  // The radicand 1 + d0 - d1 - d2 of four 32-bit terms fits in 35 bits.
  localparam int unsigned RAD_W = 35;
  localparam int unsigned NUM_W = 33;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_M00   = 2'd1,
    BR_M11   = 2'd2,
    BR_M22   = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m01;
    logic signed [ELEM_W-1:0] m02;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
  } d2q_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] q_scalar;
    logic signed [ELEM_W-1:0] q_x;
    logic signed [ELEM_W-1:0] q_y;
    logic signed [ELEM_W-1:0] q_z;
    logic [1:0]               branch_taken;
    logic                     bad_matrix;
  } d2q_out_t;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    logic signed [RAD_W-1:0] rad;
    logic signed [NUM_W-1:0] n0;
    logic signed [NUM_W-1:0] n1;
    logic signed [NUM_W-1:0] n2;
    branch_t                 br;
  } d2q_cls_t;

endpackage

>>> src/d2q_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix to quaternion front end
// Picks the branch, forms the radicand and the three off-diagonal numerators.
// ----------------------------------------------------------------------------
module d2q_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  d2q_pkg::d2q_in_t  in_data,
  output logic              in_ready,
  output logic              cls_valid,
  output d2q_pkg::d2q_cls_t cls_data,
  input  logic              cls_ready,
  input  logic [d2q_pkg::RAD_W-1:0] one_val
);
  import d2q_pkg::*;

  logic signed [RAD_W-1:0] a00, a11, a22, trace;
  logic signed [NUM_W-1:0] d12, d20, d01, s01, s02, s12;
  d2q_cls_t cls_next;

  always_comb begin
    a00 = RAD_W'(in_data.m00);
    a11 = RAD_W'(in_data.m11);
    a22 = RAD_W'(in_data.m22);
    d12 = NUM_W'(in_data.m12) - NUM_W'(in_data.m21);
    d20 = NUM_W'(in_data.m20) - NUM_W'(in_data.m02);
    d01 = NUM_W'(in_data.m01) - NUM_W'(in_data.m10);
    s01 = NUM_W'(in_data.m01) + NUM_W'(in_data.m10);
    s02 = NUM_W'(in_data.m02) + NUM_W'(in_data.m20);
    s12 = NUM_W'(in_data.m12) + NUM_W'(in_data.m21);
    trace = a00 + a11 + a22;
    if (trace > 0) begin
      cls_next = '{rad: $signed(one_val) + trace, n0: d12, n1: d20, n2: d01, br: BR_TRACE};
    end else if (a00 > a11 && a00 > a22) begin
      cls_next = '{rad: $signed(one_val) + a00 - a11 - a22, n0: d12, n1: s01, n2: s02,
                   br: BR_M00};
    end else if (a11 > a22) begin
      cls_next = '{rad: $signed(one_val) + a11 - a00 - a22, n0: d20, n1: s01, n2: s12,
                   br: BR_M11};
    end else begin
      cls_next = '{rad: $signed(one_val) + a22 - a00 - a11, n0: d01, n1: s02, n2: s12,
                   br: BR_M22};
    end
  end

  assign in_ready = !cls_valid || cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (in_ready) begin
      cls_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cls_data <= cls_next;
    end
  end
endmodule

>>> src/d2q_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix to quaternion back end
// Pipelined square root, then three pipelined dividers, one bit per stage.
// ----------------------------------------------------------------------------
module d2q_back #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              cls_valid,
  input  d2q_pkg::d2q_cls_t cls_data,
  output logic              res_valid,
  output d2q_pkg::d2q_out_t res_data
);
  import d2q_pkg::*;

  localparam int unsigned RV_W  = RAD_W + FRAC_BITS;         // radicand << FRAC_BITS
  localparam int unsigned RT_W  = (RV_W + 1) / 2;            // root width
  localparam int unsigned SQ_N  = RT_W;                      // root stages
  localparam int unsigned NM_W  = NUM_W + FRAC_BITS;         // dividend width
  localparam int unsigned DV_N  = NM_W;                      // divider stages
  localparam int unsigned DW    = RT_W + 2;                  // divisor width
  localparam int unsigned RM_W  = DW + 1;
  localparam int unsigned TOT   = SQ_N + DV_N;

  typedef struct packed {
    logic [RV_W-1:0]   rem;
    logic [RT_W-1:0]   root;
    logic [NM_W-1:0]   mag0, mag1, mag2;
    logic [2:0]        neg;
    branch_t           br;
    logic              bad;
  } sq_t;

  typedef struct packed {
    logic [RM_W-1:0]   r0, r1, r2;
    logic [NM_W-1:0]   q0, q1, q2;
    logic [DW-1:0]     s;
    logic [RT_W-1:0]   root;
    logic [2:0]        neg;
    branch_t           br;
    logic              bad;
  } dv_t;

  sq_t  sq [SQ_N+1];
  dv_t  dv [DV_N+1];
  // Bit k marks a valid beat in the (k+1)th stage register after the front register,
  // root stages first, so the top bit lines up with the last divider stage.
  logic [TOT-1:0] vld;

  function automatic logic [NM_W-1:0] mag_of(input logic signed [NUM_W-1:0] n);
    logic [NUM_W-1:0] m;
    m = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    return {m, {FRAC_BITS{1'b0}}};
  endfunction

  always_comb begin
    sq[0].rem  = cls_data.rad[RAD_W-1] ? '0 : {RV_W'(cls_data.rad) << FRAC_BITS};
    sq[0].root = '0;
    sq[0].mag0 = mag_of(cls_data.n0);
    sq[0].mag1 = mag_of(cls_data.n1);
    sq[0].mag2 = mag_of(cls_data.n2);
    sq[0].neg  = {cls_data.n2[NUM_W-1], cls_data.n1[NUM_W-1], cls_data.n0[NUM_W-1]};
    sq[0].br   = cls_data.br;
    sq[0].bad  = (cls_data.rad <= 0);
  end

  // Digit-by-digit root: remainder form, one result bit per stage.
  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    localparam int unsigned B = SQ_N - 1 - i;
    logic [2*RT_W+1:0] trial, remx;
    sq_t sq_next;
    always_comb begin
      remx  = (2*RT_W+2)'(sq[i].rem);
      trial = ((2*RT_W+2)'(sq[i].root) << (B + 1)) | ((2*RT_W+2)'(1) << (2 * B));
      sq_next = sq[i];
      if (remx >= trial) begin
        sq_next.rem  = RV_W'(remx - trial);
        sq_next.root = sq[i].root | (RT_W'(1) << B);
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        sq[i+1] <= sq_next;
      end
    end
  end

  always_comb begin
    dv[0].r0   = '0;
    dv[0].r1   = '0;
    dv[0].r2   = '0;
    dv[0].q0   = sq[SQ_N].mag0;
    dv[0].q1   = sq[SQ_N].mag1;
    dv[0].q2   = sq[SQ_N].mag2;
    dv[0].s    = {1'b0, sq[SQ_N].root, 1'b0};
    dv[0].root = sq[SQ_N].root;
    dv[0].neg  = sq[SQ_N].neg;
    dv[0].br   = sq[SQ_N].br;
    dv[0].bad  = sq[SQ_N].bad;
  end

  // Restoring division; the quotient shifts into the dividend register.
  for (genvar i = 0; i < DV_N; i++) begin : g_dv
    logic [RM_W-1:0] t0, t1, t2, sx;
    dv_t dv_next;
    always_comb begin
      sx = RM_W'(dv[i].s);
      t0 = {dv[i].r0[RM_W-2:0], dv[i].q0[NM_W-1]};
      t1 = {dv[i].r1[RM_W-2:0], dv[i].q1[NM_W-1]};
      t2 = {dv[i].r2[RM_W-2:0], dv[i].q2[NM_W-1]};
      dv_next    = dv[i];
      dv_next.r0 = (sx != 0 && t0 >= sx) ? t0 - sx : t0;
      dv_next.r1 = (sx != 0 && t1 >= sx) ? t1 - sx : t1;
      dv_next.r2 = (sx != 0 && t2 >= sx) ? t2 - sx : t2;
      dv_next.q0 = {dv[i].q0[NM_W-2:0], sx != 0 && t0 >= sx};
      dv_next.q1 = {dv[i].q1[NM_W-2:0], sx != 0 && t1 >= sx};
      dv_next.q2 = {dv[i].q2[NM_W-2:0], sx != 0 && t2 >= sx};
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        dv[i+1] <= dv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[TOT-2:0], cls_valid};
    end
  end

  localparam logic [NM_W-1:0] ONE_Q = NM_W'(1) << FRAC_BITS;

  function automatic logic [ELEM_W-1:0] fin(input logic [NM_W-1:0] q, input logic n);
    logic [NM_W-1:0] m;
    m = (q > ONE_Q) ? ONE_Q : q;
    return n ? ELEM_W'(-m) : ELEM_W'(m);
  endfunction

  logic [NM_W-1:0] selq;
  logic [ELEM_W-1:0] p0, p1, p2, ps;
  dv_t last;

  always_comb begin
    last = dv[DV_N];
    selq = NM_W'(last.root >> 1);
    ps   = fin(selq, 1'b0);
    p0   = fin(last.q0, last.neg[0]);
    p1   = fin(last.q1, last.neg[1]);
    p2   = fin(last.q2, last.neg[2]);
    res_data.branch_taken = last.br;
    res_data.bad_matrix   = last.bad;
    res_data.q_scalar = '0;
    res_data.q_x      = '0;
    res_data.q_y      = '0;
    res_data.q_z      = '0;
    if (!last.bad) begin
      unique case (last.br)
        BR_TRACE: begin
          res_data.q_scalar = ps; res_data.q_x = p0; res_data.q_y = p1; res_data.q_z = p2;
        end
        BR_M00: begin
          res_data.q_scalar = p0; res_data.q_x = ps; res_data.q_y = p1; res_data.q_z = p2;
        end
        BR_M11: begin
          res_data.q_scalar = p0; res_data.q_x = p1; res_data.q_y = ps; res_data.q_z = p2;
        end
        default: begin
          res_data.q_scalar = p0; res_data.q_x = p1; res_data.q_y = p2; res_data.q_z = ps;
        end
      endcase
    end
  end

  assign res_valid = vld[TOT-1];
endmodule

>>> src/dcm_to_quaternion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction cosine matrix to quaternion
// Shepperd conversion with a pipelined root and dividers.
// ----------------------------------------------------------------------------
// One matrix is accepted per cycle while the output queue has room. The
// accepting edge loads the front register, then the bit-per-stage root
// pipeline, three parallel bit-per-stage dividers and a write into the
// output queue follow. At the default FRAC_BITS of 30, values are Q1.30. The
// pipeline advances whenever its last stage may move on, and a two-beat
// output queue keeps results while pop is low.
module dcm_to_quaternion_core #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  d2q_pkg::d2q_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output d2q_pkg::d2q_out_t out_item
);
  import d2q_pkg::*;

  localparam logic [RAD_W-1:0] ONE_VAL = RAD_W'(1) << FRAC_BITS;

  logic      in_ready, cls_valid, cls_ready, res_valid, advance;
  d2q_cls_t  cls_data;
  d2q_out_t  res_data;
  d2q_out_t  obuf [2];
  logic      wp, rp;
  logic [1:0] cnt;

  d2q_front u_front (
    .clk(clk), .rst(rst), .in_valid(push), .in_data(in_item), .in_ready(in_ready),
    .cls_valid(cls_valid), .cls_data(cls_data), .cls_ready(cls_ready), .one_val(ONE_VAL)
  );

  d2q_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .advance(advance), .cls_valid(cls_valid), .cls_data(cls_data),
    .res_valid(res_valid), .res_data(res_data)
  );

  logic do_pop, do_push;
  assign do_pop   = pop && !empty;
  // The pipeline may shift if its output beat has somewhere to go.
  assign advance  = !res_valid || cnt < 2'd2 || do_pop;
  assign do_push  = advance && res_valid;
  assign cls_ready = advance;
  assign full     = !in_ready;
  assign empty    = (cnt == 2'd0);
  assign out_item = obuf[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) obuf[wp] <= res_data;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("output queue overflow");
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    res_valid && !advance |=> res_valid && $stable(res_data))
    else $error("pipeline result lost while stalled");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.bad_matrix |-> res_data.q_scalar == 0 && res_data.q_x == 0)
    else $error("bad matrix with non-zero output");
endmodule

>>> bench/d2q_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix to quaternion checker
// Watches both queue ports, predicts each quaternion when a matrix beat is
// accepted, and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module d2q_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  d2q_pkg::d2q_in_t  in_item,
  input  logic              empty,
  input  logic              pop,
  input  d2q_pkg::d2q_out_t out_item,
  output int                errors,
  output int                pending
);
  import d2q_pkg::*;

  localparam int unsigned FRAC = 30;
  localparam logic [63:0] ONE = 64'd1 << FRAC;

  d2q_out_t quat_fifo[$];

  // Quotient of |num| * 2^FRAC by s, truncated and saturated to one.
  function automatic logic signed [31:0] scaled_ratio(longint num, logic [63:0] s);
    logic [127:0] mag;
    logic [127:0] quo;
    begin
      mag = (num < 0) ? 128'(-num) : 128'(num);
      quo = (mag << FRAC) / {64'd0, s};
      if (quo > {64'd0, ONE}) quo = {64'd0, ONE};
      return (num < 0) ? -32'(quo) : 32'(quo);
    end
  endfunction

  function automatic d2q_out_t quat_of(d2q_in_t x);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad;
    logic [127:0] v, sq;
    logic [63:0] root, cand, s;
    logic signed [31:0] sel;
    d2q_out_t o;
    begin
      a00 = x.m00; a01 = x.m01; a02 = x.m02;
      a10 = x.m10; a11 = x.m11; a12 = x.m12;
      a20 = x.m20; a21 = x.m21; a22 = x.m22;
      o = '0;
      tr = a00 + a11 + a22;
      if (tr > 0) begin
        o.branch_taken = BR_TRACE;
        rad = longint'(ONE) + tr;
      end else if (a00 > a11 && a00 > a22) begin
        o.branch_taken = BR_M00;
        rad = longint'(ONE) + a00 - a11 - a22;
      end else if (a11 > a22) begin
        o.branch_taken = BR_M11;
        rad = longint'(ONE) + a11 - a00 - a22;
      end else begin
        o.branch_taken = BR_M22;
        rad = longint'(ONE) + a22 - a00 - a11;
      end
      o.bad_matrix = (rad <= 0);
      if (!o.bad_matrix) begin
        v = 128'(rad) << FRAC;
        root = '0;
        for (int b = 63; b >= 0; b--) begin
          cand = root | (64'd1 << b);
          sq = {64'd0, cand} * {64'd0, cand};
          if (sq <= v) root = cand;
        end
        s = root << 1;
        sel = ((root >> 1) > ONE) ? 32'(ONE) : 32'(root >> 1);
        case (branch_t'(o.branch_taken))
          BR_TRACE: begin
            o.q_scalar = sel;
            o.q_x = scaled_ratio(a12 - a21, s);
            o.q_y = scaled_ratio(a20 - a02, s);
            o.q_z = scaled_ratio(a01 - a10, s);
          end
          BR_M00: begin
            o.q_scalar = scaled_ratio(a12 - a21, s);
            o.q_x = sel;
            o.q_y = scaled_ratio(a01 + a10, s);
            o.q_z = scaled_ratio(a02 + a20, s);
          end
          BR_M11: begin
            o.q_scalar = scaled_ratio(a20 - a02, s);
            o.q_x = scaled_ratio(a01 + a10, s);
            o.q_y = sel;
            o.q_z = scaled_ratio(a12 + a21, s);
          end
          default: begin
            o.q_scalar = scaled_ratio(a01 - a10, s);
            o.q_x = scaled_ratio(a02 + a20, s);
            o.q_y = scaled_ratio(a12 + a21, s);
            o.q_z = sel;
          end
        endcase
      end
      return o;
    end
  endfunction

  always @(posedge clk) begin
    d2q_out_t exp_q;
    if (rst) begin
      errors = 0;
    end else begin
      if (push && !full) quat_fifo.push_back(quat_of(in_item));
      if (pop && !empty) begin
        if (quat_fifo.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, out_item);
          errors++;
        end else begin
          exp_q = quat_fifo.pop_front();
          if (out_item.q_scalar !== exp_q.q_scalar || out_item.q_x !== exp_q.q_x ||
              out_item.q_y !== exp_q.q_y || out_item.q_z !== exp_q.q_z ||
              out_item.branch_taken !== exp_q.branch_taken ||
              out_item.bad_matrix !== exp_q.bad_matrix) begin
            $display("%0t: mismatch expected a=%h b=%h c=%h d=%h br=%0d bad=%0b",
                     $realtime, exp_q.q_scalar, exp_q.q_x, exp_q.q_y, exp_q.q_z,
                     exp_q.branch_taken, exp_q.bad_matrix);
            $display("%0t:          actual   a=%h b=%h c=%h d=%h br=%0d bad=%0b",
                     $realtime, out_item.q_scalar, out_item.q_x, out_item.q_y,
                     out_item.q_z, out_item.branch_taken, out_item.bad_matrix);
            errors++;
          end
        end
      end
    end
    pending = quat_fifo.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

>>> bench/tb_dcm_to_quaternion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix to quaternion testbench
// Drives directed and random matrices in bursts, pops results on a pattern
// of its own with one long hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_dcm_to_quaternion_core;
  import d2q_pkg::*;

  localparam int N_RANDOM = 1780;
  localparam logic signed [31:0] P1 = 32'sd1073741824;
  localparam logic signed [31:0] N1 = -32'sd1073741824;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full, empty;
  d2q_in_t  in_item = '0;
  d2q_out_t out_item;
  int       errors, pending;
  logic     hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dcm_to_quaternion_core u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  d2q_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .errors(errors), .pending(pending)
  );

  function automatic logic signed [31:0] to_q30(real x);
    return 32'($rtoi(x * 1073741824.0));
  endfunction

  function automatic real rnd_unit();
    int k;
    begin
      k = int'($urandom_range(2000)) - 1000;
      return k / 1000.0;
    end
  endfunction

  // Rotation matrix built from a random unit quaternion.
  function automatic d2q_in_t rotation();
    real a, b, c, d, n;
    d2q_in_t m;
    begin
      do begin
        a = rnd_unit(); b = rnd_unit(); c = rnd_unit(); d = rnd_unit();
        n = a * a + b * b + c * c + d * d;
      end while (n < 0.01);
      n = $sqrt(n);
      a = a / n; b = b / n; c = c / n; d = d / n;
      m.m00 = to_q30(1.0 - 2.0 * (c * c + d * d));
      m.m01 = to_q30(2.0 * (b * c - a * d));
      m.m02 = to_q30(2.0 * (b * d + a * c));
      m.m10 = to_q30(2.0 * (b * c + a * d));
      m.m11 = to_q30(1.0 - 2.0 * (b * b + d * d));
      m.m12 = to_q30(2.0 * (c * d - a * b));
      m.m20 = to_q30(2.0 * (b * d - a * c));
      m.m21 = to_q30(2.0 * (c * d + a * b));
      m.m22 = to_q30(1.0 - 2.0 * (b * b + c * c));
      return m;
    end
  endfunction

  function automatic d2q_in_t random_matrix();
    d2q_in_t m;
    int sel;
    begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        m = rotation();
      end else if (sel < 8) begin
        m = rotation();
        // Small disturbance of a nearly valid rotation.
        m.m00 = m.m00 + 32'(int'($urandom_range(2000)) - 1000);
        m.m11 = m.m11 - 32'(int'($urandom_range(2000)) - 1000);
        m.m22 = m.m22 + 32'(int'($urandom_range(2000)) - 1000);
      end else begin
        for (int i = 0; i < 9; i++) m[i*32 +: 32] = $urandom();
      end
      return m;
    end
  endfunction

  // Holds one matrix on the port until a beat is accepted.
  task automatic send_matrix(d2q_in_t m);
    logic was_full;
    begin
      push <= 1'b1;
      in_item <= m;
      do begin
        @(negedge clk);
        was_full = full;
        @(posedge clk);
      end while (was_full);
    end
  endtask

  task automatic maybe_gap();
    int gap;
    begin
      if ($urandom_range(3) == 0) begin
        gap = $urandom_range(1, 6);
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: random stalls, long clean stretches, and one long hold-off.
  initial begin
    int mode;
    int run;
    pop = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req <= 1'b0;
      end
      mode = $urandom_range(3);
      run = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(3) != 0);
          2: pop <= ($urandom_range(3) == 0);
          default: pop <= $urandom_range(1);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    d2q_in_t m;
    int burst;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity, half turns about each axis, zero, and corner patterns.
    send_matrix('{P1, 0, 0, 0, P1, 0, 0, 0, P1});
    send_matrix('{P1, 0, 0, 0, N1, 0, 0, 0, N1});
    send_matrix('{N1, 0, 0, 0, P1, 0, 0, 0, N1});
    send_matrix('{N1, 0, 0, 0, N1, 0, 0, 0, P1});
    send_matrix('0);
    send_matrix('{N1, N1, N1, N1, N1, N1, N1, N1, N1});
    send_matrix('{P1, P1, P1, P1, P1, P1, P1, P1, P1});
    send_matrix({9{32'h80000000}});
    send_matrix({9{32'h7fffffff}});
    send_matrix({9{32'hffffffff}});
    send_matrix('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
    // Ties on the diagonal with a non-positive trace.
    send_matrix('{0, P1, 0, 0, 0, N1, 0, 0, 0});
    send_matrix('{N1, 0, 0, 0, 0, 0, 0, 0, 0});
    send_matrix('{0, 0, 0, 0, N1, 0, 0, 0, N1});
    send_matrix('{N1, 0, 0, 0, N1, 0, 0, 0, 0});
    send_matrix('{0, 0, P1, 0, N1, 0, N1, 0, 0});
    // Trace of exactly zero and just above zero.
    send_matrix('{P1, 0, 0, 0, 0, 0, 0, 0, N1});
    send_matrix('{P1, 0, 0, 0, 1, 0, 0, 0, N1});

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_req <= 1'b1;
      if (i == 900) begin
        push <= 1'b0;
        // A clock edge lets the checker count the beat accepted just before.
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      m = random_matrix();
      send_matrix(m);
      burst = $urandom_range(15);
      if (burst == 0) maybe_gap();
    end
    push <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
